// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the page frame allocator checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define PFA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pfa assertion failed");

// check a property on every clock edge, reset included
`define PFA_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("pfa assertion failed");

`endif

// File: sv/pfa_pkg.sv
// ----------------------------------------------------------------------------
// Page frame allocator package
// Transaction types, operation and status codes, controller interface types.
// ----------------------------------------------------------------------------
package pfa_pkg;

   localparam int ADDR_W  = 24;
   localparam int END_W   = 25;
   localparam int ARITH_W = 26;
   localparam int WORD_W  = 32;
   localparam int BIT_W   = 5;

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_AVAIL = 2'd2;
   localparam logic [1:0] OP_RSVD  = 2'd3;

   localparam logic [1:0] STS_OK         = 2'd0;
   localparam logic [1:0] STS_NO_FRAME   = 2'd1;
   localparam logic [1:0] STS_MISALIGNED = 2'd2;
   localparam logic [1:0] STS_BEYOND     = 2'd3;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [ADDR_W-1:0] address;
      logic [END_W-1:0]  range_end;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] frame_address;
      logic [1:0]        status;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic rd;
      logic modify;
      logic step;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic skip;
      logic done;
   } stat_type;

endpackage

// File: sv/pfa_dpath.sv
// ----------------------------------------------------------------------------
// Page frame allocator datapath
// Word-wide frame bitmap memory, range decode, mask and first-fit search.
// ----------------------------------------------------------------------------
module pfa_dpath #(
   parameter int FRAME_COUNT = 4096,
   parameter int PAGE_SIZE   = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  pfa_pkg::req_type req_data,
   input  pfa_pkg::cmd_type cmd,
   output pfa_pkg::stat_type stat,
   output pfa_pkg::rsp_type rsp_data
);
   import pfa_pkg::*;

   localparam int WORD_COUNT = (FRAME_COUNT + WORD_W - 1) / WORD_W;
   localparam int WA_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int PS_W       = $clog2(PAGE_SIZE);
   localparam logic [ARITH_W-1:0] FC      = ARITH_W'(FRAME_COUNT);
   localparam logic [ARITH_W-1:0] PG_M1   = ARITH_W'(PAGE_SIZE - 1);
   localparam logic [WA_W-1:0]    WA_LAST = WA_W'(WORD_COUNT - 1);

   logic [WORD_W-1:0] mem [WORD_COUNT];

   logic [WA_W-1:0]    wp_ff, wp_in;
   logic [WA_W-1:0]    fword_ff, fword_in;
   logic [WA_W-1:0]    end_ff, end_in;
   logic [BIT_W-1:0]   lo_ff, lo_in;
   logic [BIT_W-1:0]   hi_ff, hi_in;
   logic [1:0]         op_ff;
   logic [WORD_W-1:0]  rdata_ff;
   logic [ADDR_W-1:0]  res_addr_ff;
   logic [1:0]         res_status_ff, res_status_in;
   rsp_type            rsp_ff;

   logic [ARITH_W-1:0] a_v, r_v, free_f, first_v, last_v, last_c, lm1;
   logic               misaligned, beyond, empty;
   logic               skip_c;
   logic [BIT_W-1:0]   low_idx, lo_eff, hi_eff;
   logic               found;
   logic [WORD_W-1:0]  mask, new_word;
   logic [WORD_W-1:0]  found_frame;
   logic [43:0]        found_addr;

   always_comb begin
      a_v        = ARITH_W'(req_data.address);
      r_v        = ARITH_W'(req_data.range_end);
      misaligned = (a_v & PG_M1) != '0;
      free_f     = a_v >> PS_W;
      beyond     = free_f >= FC;
      unique case (req_data.opcode)
         OP_ALLOC: begin
            first_v = '0;
            last_v  = FC;
         end
         OP_FREE: begin
            first_v = free_f;
            last_v  = free_f + ARITH_W'(1);
         end
         OP_AVAIL: begin
            first_v = (a_v + PG_M1) >> PS_W;
            last_v  = r_v >> PS_W;
         end
         default: begin
            first_v = a_v >> PS_W;
            last_v  = (r_v + PG_M1) >> PS_W;
         end
      endcase
      last_c   = (last_v > FC) ? FC : last_v;
      empty    = first_v >= last_c;
      lm1      = last_c - ARITH_W'(1);
      fword_in = WA_W'(first_v >> BIT_W);
      lo_in    = first_v[BIT_W-1:0];
      end_in   = WA_W'(lm1 >> BIT_W);
      hi_in    = lm1[BIT_W-1:0];
      unique case (req_data.opcode)
         OP_ALLOC: res_status_in = STS_NO_FRAME;
         OP_FREE:  res_status_in = misaligned ? STS_MISALIGNED :
                                   (beyond ? STS_BEYOND : STS_OK);
         default:  res_status_in = STS_OK;
      endcase
      unique case (req_data.opcode)
         OP_ALLOC: skip_c = 1'b0;
         OP_FREE:  skip_c = misaligned || beyond;
         default:  skip_c = empty;
      endcase
   end

   always_comb begin
      low_idx = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (rdata_ff[i]) begin
            low_idx = BIT_W'(i);
         end
      end
      found  = |rdata_ff;
      lo_eff = (wp_ff == fword_ff) ? lo_ff : '0;
      hi_eff = (wp_ff == end_ff) ? hi_ff : BIT_W'(WORD_W - 1);
      for (int i = 0; i < WORD_W; i++) begin
         mask[i] = (BIT_W'(i) >= lo_eff) && (BIT_W'(i) <= hi_eff);
      end
      if (op_ff == OP_ALLOC) begin
         new_word = found ? (rdata_ff & ~(WORD_W'(1) << low_idx)) : rdata_ff;
      end else if (op_ff == OP_RSVD) begin
         new_word = rdata_ff & ~mask;
      end else begin
         new_word = rdata_ff | mask;
      end
      found_frame   = (WORD_W'(wp_ff) << BIT_W) | WORD_W'(low_idx);
      found_addr    = 44'(found_frame) << PS_W;
      stat.skip     = skip_c;
      stat.done     = (wp_ff == end_ff) || ((op_ff == OP_ALLOC) && found);
      stat.clr_last = wp_ff == WA_LAST;
   end

   always_comb begin
      wp_in = wp_ff;
      if (cmd.clear || cmd.step) begin
         wp_in = wp_ff + WA_W'(1);
      end else if (cmd.load) begin
         wp_in = fword_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
      end else begin
         wp_ff <= wp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff         <= req_data.opcode;
         fword_ff      <= fword_in;
         end_ff        <= end_in;
         lo_ff         <= lo_in;
         hi_ff         <= hi_in;
         res_addr_ff   <= '0;
         res_status_ff <= res_status_in;
      end else if (cmd.modify && (op_ff == OP_ALLOC) && found) begin
         res_addr_ff   <= found_addr[ADDR_W-1:0];
         res_status_ff <= STS_OK;
      end
      if (cmd.publish) begin
         rsp_ff.frame_address <= res_addr_ff;
         rsp_ff.status        <= res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         mem[wp_ff] <= '0;
      end else if (cmd.modify) begin
         mem[wp_ff] <= new_word;
      end
      if (cmd.rd) begin
         rdata_ff <= mem[wp_ff];
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// File: sv/pfa_ctrl.sv
// ----------------------------------------------------------------------------
// Page frame allocator controller
// Sequences the clearing pass, word read-modify-write walk and response.
// ----------------------------------------------------------------------------
module pfa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  pfa_pkg::stat_type stat,
   output pfa_pkg::cmd_type  cmd
);
   import pfa_pkg::*;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_READ   = 3'd2;
   localparam logic [2:0] S_MODIFY = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = stat.skip ? S_DONE : S_READ;
            end
         end
         S_READ: begin
            cmd.rd   = 1'b1;
            state_in = S_MODIFY;
         end
         S_MODIFY: begin
            cmd.modify = 1'b1;
            if (stat.done) begin
               state_in = S_DONE;
            end else begin
               cmd.step = 1'b1;
               state_in = S_READ;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
      rsp_valid_in = cmd.publish ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: sv/page_frame_allocator.sv
// ----------------------------------------------------------------------------
// Page frame allocator
// First-fit bitmap allocator over physical page frames, one mark per frame.
// ----------------------------------------------------------------------------
// Usage: req_ carries one operation per transaction (allocate, free, mark a
// byte range available, mark a byte range reserved); rsp_ returns exactly one
// transaction per request with the frame address and a status code.
// PAGE_SIZE must be a power of two.
// The map sits in a memory of 32-bit words, one word read or written per
// cycle; each word visited is read and then written back.
// Sequence: a failed free or an empty range answers without touching the map;
// free visits its one word; allocate scans words up to the first available
// frame, at most every word of the map; a range mark visits every word it
// covers. One request is in work at a time.
// Reset: every frame becomes reserved through a clearing pass over all
// ceil(FRAME_COUNT / 32) words (128 at the default size) during which
// req_ready stays low.
// Stall: the response sits in an output register; a new request is taken
// while it waits, and the next result is held back until it is taken.
// ----------------------------------------------------------------------------
module page_frame_allocator #(
   parameter int FRAME_COUNT = 4096,
   parameter int PAGE_SIZE   = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pfa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pfa_pkg::rsp_type rsp_data
);
   import pfa_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   pfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pfa_dpath #(
      .FRAME_COUNT (FRAME_COUNT),
      .PAGE_SIZE   (PAGE_SIZE)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

// File: sv/pfa_checker.sv
// ----------------------------------------------------------------------------
// Page frame allocator checker
// Port-level checks on the allocator's handshakes and responses.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfa_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input pfa_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input pfa_pkg::rsp_type rsp_data
);
   import pfa_pkg::*;

   `PFA_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
   `PFA_ASSERT_ALWAYS(a_clear_blocks, clock, reset |=> !req_ready)
   `PFA_ASSERT(a_one_at_a_time, clock, reset, req_valid && req_ready |=> !req_ready)
   `PFA_ASSERT(a_fail_zero_addr, clock, reset, rsp_valid && rsp_data.status != STS_OK |-> rsp_data.frame_address == '0)

endmodule

bind page_frame_allocator pfa_checker u_pfa_checker (.*);
